// ===== rtl/vmf_pkg.sv =====
// Shared constants, types and sizes of the 3x3x3 volume median filter.
// Used by vmf_front, vmf_queue, vmf_back and the top level; depends on nothing else.
package vmf_pkg;

  localparam int MaxColumns = 128;
  localparam int MaxRows    = 128;
  localparam int SampleBits = 16;
  localparam int SliceW     = 16;
  localparam int CfgW       = 16;
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRows    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSlices  = 2'd2;

  localparam int ColW   = $clog2(MaxColumns);
  localparam int RowW   = $clog2(MaxRows);
  localparam int DimCW  = ColW + 1;
  localparam int DimRW  = RowW + 1;
  localparam int PlaneW = $clog2(MaxRows * MaxColumns + 1);
  localparam int LagW   = $clog2(MaxRows * MaxColumns + MaxColumns + 3);

  // History ring: a power of two well above two slices plus two rows, so the
  // back end may trail the front end by a queue's worth of voxels.
  localparam int HistDepth = 1 << $clog2(2 * MaxRows * MaxColumns + 2 * MaxColumns + 67);
  localparam int HistAw    = $clog2(HistDepth);

  localparam int Window = 27;
  localparam int WinIdxW = $clog2(Window);
  localparam int WinCntW = $clog2(Window + 1);

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam int OutBits  = SampleBits + 1;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

  typedef struct packed {
    logic [DimCW-1:0]  nc;
    logic [DimRW-1:0]  nr;
    logic [SliceW-1:0] ns;
    logic [PlaneW-1:0] plane;
  } vmf_dims_t;

  typedef struct packed {
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [SliceW-1:0] slice;
    logic [HistAw-1:0] lin;
    logic              last;
  } vmf_job_t;

endpackage

// ===== rtl/vmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module vmf_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vmf_front.sv =====
// Front end: configuration registers, input and output voxel counters,
// history writes and issue of one median job per due result. Uses vmf_pkg.
module vmf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vmf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vmf_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_kind_i,
  input  logic [vmf_pkg::SampleBits-1:0] in_sample_i,
  output logic                          in_ready_o,
  input  logic                          q_full_i,
  output logic                          push_o,
  output vmf_pkg::vmf_job_t             job_o,
  output vmf_pkg::vmf_dims_t            dims_o,
  output logic                          hist_we_o,
  output logic [vmf_pkg::HistAw-1:0]    hist_waddr_o,
  output logic [vmf_pkg::SampleBits-1:0] hist_wdata_o
);
  import vmf_pkg::*;

  logic [7:0]        cols_q, rows_q;
  logic [SliceW-1:0] slices_q;
  logic [ColW-1:0]   in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RowW-1:0]   in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SliceW-1:0] in_slice_q, in_slice_d, out_slice_q, out_slice_d;
  logic [LagW-1:0]   pend_q, pend_d, pend_inc, lag;
  logic [HistAw-1:0] in_addr_q, in_addr_d, out_lin_q, out_lin_d;
  logic [DimCW-1:0]  nc;
  logic [DimRW-1:0]  nr;
  logic [SliceW-1:0] ns;
  logic [PlaneW-1:0] plane;
  logic              accept, sample_go, in_done_n, emit, last, in_col_wrap, in_row_wrap;
  logic              out_col_wrap, out_row_wrap;

  always_comb begin
    if (cols_q == '0) nc = DimCW'(1);
    else if (32'(cols_q) > MaxColumns) nc = DimCW'(MaxColumns);
    else nc = DimCW'(cols_q);
    if (rows_q == '0) nr = DimRW'(1);
    else if (32'(rows_q) > MaxRows) nr = DimRW'(MaxRows);
    else nr = DimRW'(rows_q);
    ns = (slices_q == '0) ? SliceW'(1) : slices_q;
  end

  assign plane  = PlaneW'(32'(nr) * 32'(nc));
  assign lag    = LagW'(plane) + LagW'(nc) + LagW'(1);
  assign dims_o = '{nc: nc, nr: nr, ns: ns, plane: plane};

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sample_go  = accept && !in_kind_i && (in_slice_q < ns);

  assign in_col_wrap = (DimCW'(in_col_q) + DimCW'(1)) >= nc;
  assign in_row_wrap = (DimRW'(in_row_q) + DimRW'(1)) >= nr;

  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slice_d = in_slice_q;
    if (sample_go) begin
      if (in_col_wrap) begin
        in_col_d = '0;
        if (in_row_wrap) begin
          in_row_d   = '0;
          in_slice_d = in_slice_q + SliceW'(1);
        end else begin
          in_row_d = in_row_q + RowW'(1);
        end
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
    end
  end

  // A result is due once the whole neighborhood is in, or the volume is complete.
  assign in_done_n = in_slice_d >= ns;
  assign pend_inc  = pend_q + LagW'(sample_go);
  assign emit      = accept && (in_done_n || pend_inc >= lag + LagW'(1));

  assign out_col_wrap = (DimCW'(out_col_q) + DimCW'(1)) >= nc;
  assign out_row_wrap = (DimRW'(out_row_q) + DimRW'(1)) >= nr;
  assign last = out_col_wrap && out_row_wrap &&
                ({1'b0, out_slice_q} + 17'd1 >= {1'b0, ns});

  assign in_addr_d = in_addr_q + HistAw'(sample_go);

  always_comb begin
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_slice_d = out_slice_q;
    out_lin_d   = out_lin_q;
    pend_d      = pend_inc - LagW'(emit);
    if (emit) begin
      out_lin_d = out_lin_q + HistAw'(1);
      if (out_col_wrap) begin
        out_col_d = '0;
        if (out_row_wrap) begin
          out_row_d   = '0;
          out_slice_d = out_slice_q + SliceW'(1);
        end else begin
          out_row_d = out_row_q + RowW'(1);
        end
      end else begin
        out_col_d = out_col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= 8'd128;
      rows_q      <= 8'd128;
      slices_q    <= SliceW'(1);
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slice_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slice_q <= '0;
      pend_q      <= '0;
      in_addr_q   <= '0;
      out_lin_q   <= '0;
    end else if (cfg_we_i && (cfg_idx_i == RegColumns || cfg_idx_i == RegRows ||
                              cfg_idx_i == RegSlices)) begin
      case (cfg_idx_i)
        RegColumns: cols_q   <= cfg_data_i[7:0];
        RegRows:    rows_q   <= cfg_data_i[7:0];
        default:    slices_q <= cfg_data_i[SliceW-1:0];
      endcase
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slice_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slice_q <= '0;
      pend_q      <= '0;
      out_lin_q   <= in_addr_q;
    end else if (emit && last) begin
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slice_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slice_q <= '0;
      pend_q      <= '0;
      in_addr_q   <= in_addr_d;
      out_lin_q   <= out_lin_d;
    end else begin
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      in_slice_q  <= in_slice_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_slice_q <= out_slice_d;
      pend_q      <= pend_d;
      in_addr_q   <= in_addr_d;
      out_lin_q   <= out_lin_d;
    end
  end

  assign push_o       = emit;
  assign job_o        = '{col: out_col_q, row: out_row_q, slice: out_slice_q,
                          lin: out_lin_q, last: last};
  assign hist_we_o    = sample_go;
  assign hist_waddr_o = in_addr_q;
  assign hist_wdata_o = in_sample_i;

endmodule

// ===== rtl/vmf_queue.sv =====
// Short job queue between the front and back ends of the median filter.
// Uses vmf_pkg for the job type and depth.
module vmf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vmf_pkg::vmf_job_t job_i,
  input  logic              pop_i,
  output vmf_pkg::vmf_job_t job_o,
  output logic              full_o,
  output logic              empty_o
);
  import vmf_pkg::*;

  vmf_job_t             slot_q [QueueDepth];
  logic [QueueAw-1:0]   wr_q, rd_q;
  logic [QueueAw:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QueueAw'(1);
      if (pop_i) rd_q <= rd_q + QueueAw'(1);
      cnt_q <= cnt_q + (QueueAw+1)'(push_i) - (QueueAw+1)'(pop_i);
    end
  end

  assign job_o   = slot_q[rd_q];
  assign full_o  = cnt_q == (QueueAw+1)'(QueueDepth);
  assign empty_o = cnt_q == '0;

endmodule

// ===== rtl/vmf_back.sv =====
// Back end: walks the 27 neighbor offsets of a job, reads the history,
// keeps a sorted list and drives the output register. Uses vmf_pkg.
module vmf_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vmf_pkg::vmf_dims_t             dims_i,
  input  logic                           q_empty_i,
  input  vmf_pkg::vmf_job_t              job_i,
  output logic                           pop_o,
  output logic                           hist_re_o,
  output logic [vmf_pkg::HistAw-1:0]     hist_raddr_o,
  input  logic [vmf_pkg::SampleBits-1:0] hist_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [vmf_pkg::OutBits-1:0]    out_median_o,
  output logic                           out_last_o
);
  import vmf_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StFlush = 4'b0100,
    StEmit  = 4'b1000
  } vmf_state_e;

  vmf_state_e                    state_q, state_d;
  vmf_job_t                      job_q;
  logic [1:0]                    dx_q, dy_q, dz_q;
  logic                          take_q;
  logic signed [SampleBits-1:0]  v_q [Window];
  logic signed [SampleBits-1:0]  v_d [Window];
  logic [WinCntW-1:0]            n_q;
  logic [Window-1:0]             gt;
  logic signed [SampleBits-1:0]  key;
  logic                          nb_ok, scan_end, load_out;
  logic [HistAw-1:0]             off_z, off_y;
  logic [WinIdxW-1:0]            idx_lo, idx_hi;
  logic signed [OutBits-1:0]     twice;
  logic [OutBits-1:0]            res_q;
  logic                          res_last_q, res_valid_q;

  // A neighbor counts when every axis stays inside the volume.
  always_comb begin
    nb_ok = 1'b1;
    if (dz_q == 2'd0 && job_q.slice == '0) nb_ok = 1'b0;
    if (dz_q == 2'd2 && ({1'b0, job_q.slice} + 17'd1 >= {1'b0, dims_i.ns})) nb_ok = 1'b0;
    if (dy_q == 2'd0 && job_q.row == '0) nb_ok = 1'b0;
    if (dy_q == 2'd2 && (DimRW'(job_q.row) + DimRW'(1) >= dims_i.nr)) nb_ok = 1'b0;
    if (dx_q == 2'd0 && job_q.col == '0) nb_ok = 1'b0;
    if (dx_q == 2'd2 && (DimCW'(job_q.col) + DimCW'(1) >= dims_i.nc)) nb_ok = 1'b0;
  end

  always_comb begin
    case (dz_q)
      2'd0:    off_z = -HistAw'(dims_i.plane);
      2'd2:    off_z = HistAw'(dims_i.plane);
      default: off_z = '0;
    endcase
    case (dy_q)
      2'd0:    off_y = -HistAw'(dims_i.nc);
      2'd2:    off_y = HistAw'(dims_i.nc);
      default: off_y = '0;
    endcase
  end

  assign hist_raddr_o = job_q.lin + off_z + off_y + HistAw'(dx_q) - HistAw'(1);
  assign hist_re_o    = (state_q == StScan);
  assign scan_end     = dx_q == 2'd2 && dy_q == 2'd2 && dz_q == 2'd2;

  // Insertion into the sorted list: each slot decides on its own.
  assign key = hist_rdata_i;
  always_comb begin
    for (int i = 0; i < Window; i++) begin
      gt[i] = (WinCntW'(i) < n_q) && (v_q[i] > key);
    end
    for (int i = 0; i < Window; i++) begin
      if (i > 0 && gt[i-1]) v_d[i] = v_q[i-1];
      else if (gt[i] || WinCntW'(i) == n_q) v_d[i] = key;
      else v_d[i] = v_q[i];
    end
  end

  // For an odd count both indexes meet at the middle entry.
  assign idx_hi = WinIdxW'(n_q >> 1);
  assign idx_lo = WinIdxW'((n_q - WinCntW'(1)) >> 1);
  assign twice  = OutBits'(v_q[idx_lo]) + OutBits'(v_q[idx_hi]);

  assign load_out = (state_q == StEmit) && (!res_valid_q || out_ready_i);
  assign pop_o    = (state_q == StIdle) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (!q_empty_i) state_d = StScan;
      StScan:  if (scan_end) state_d = StFlush;
      StFlush: state_d = StEmit;
      StEmit:  if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (take_q) begin
      for (int i = 0; i < Window; i++) v_q[i] <= v_d[i];
    end
    if (load_out) begin
      res_q      <= twice;
      res_last_q <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      dx_q        <= '0;
      dy_q        <= '0;
      dz_q        <= '0;
      take_q      <= 1'b0;
      n_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      take_q  <= (state_q == StScan) && nb_ok;
      if (pop_o) begin
        n_q  <= '0;
        dx_q <= '0;
        dy_q <= '0;
        dz_q <= '0;
      end else begin
        if (take_q) n_q <= n_q + WinCntW'(1);
        if (state_q == StScan && !scan_end) begin
          if (dx_q == 2'd2) begin
            dx_q <= '0;
            if (dy_q == 2'd2) begin
              dy_q <= '0;
              dz_q <= dz_q + 2'd1;
            end else begin
              dy_q <= dy_q + 2'd1;
            end
          end else begin
            dx_q <= dx_q + 2'd1;
          end
        end
      end
      if (load_out) res_valid_q <= 1'b1;
      else if (out_ready_i) res_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign out_median_o = res_q;
  assign out_last_o   = res_last_q;

endmodule

// ===== rtl/volume_median_filter_3x3x3.sv =====
// Top level of the 3x3x3 volume median filter: front end, job queue,
// history RAM and back end. Uses vmf_pkg, vmf_front, vmf_queue, vmf_ram, vmf_back.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata = sample, tuser = kind
//   m_axis    out  m_axis_tvalid/tready    tdata = median_doubled, tuser = last_voxel
//   cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// An input item is taken while the job queue has room. For each result the back end
// makes 27 history reads on the one RAM read port, waits out the read latency, loads
// the output register with the median (waiting while that register is held), and
// takes the next job from the queue; this sets the rate.
// Reset clears counters and control; the history RAM is not cleared.
// A stalled output holds in its register; the queue lets the front keep taking items.
module volume_median_filter_3x3x3 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] median_doubled, [23:17] zero
  output logic        m_axis_tuser    // [0] last_voxel
);
  import vmf_pkg::*;

  vmf_job_t              push_job, head_job;
  vmf_dims_t             dims;
  logic                  push, pop, q_full, q_empty, hist_we, hist_re;
  logic [HistAw-1:0]     hist_waddr, hist_raddr;
  logic [SampleBits-1:0] hist_wdata, hist_rdata;
  logic [OutBits-1:0]    median;

  vmf_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i   (s_axis_tvalid),
    .in_kind_i    (s_axis_tuser),
    .in_sample_i  (s_axis_tdata),
    .in_ready_o   (s_axis_tready),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job),
    .dims_o       (dims),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_wdata_o (hist_wdata)
  );

  vmf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vmf_ram #(.Width(SampleBits), .Depth(HistDepth)) u_hist (
    .clk_i,
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  vmf_back u_back (
    .clk_i, .rst_ni,
    .dims_i       (dims),
    .q_empty_i    (q_empty),
    .job_i        (head_job),
    .pop_o        (pop),
    .hist_re_o    (hist_re),
    .hist_raddr_o (hist_raddr),
    .hist_rdata_i (hist_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_median_o (median),
    .out_last_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {(OutDataW - OutBits)'(0), median};

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("job pushed into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("job popped from an empty queue");

  a_pop_not_twice : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop) else $error("back end took two jobs in a row");

endmodule
